// File: rtl/core/priority_owner_election_assert.svh
// Assertion macros shared by the owner election RTL.
`ifndef PRIORITY_OWNER_ELECTION_ASSERT_SVH
`define PRIORITY_OWNER_ELECTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define POE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define POE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/poe_pkg.sv
// Types and constants of the priority owner election block.
package poe_pkg;

    localparam int ID_W    = 32;
    localparam int STAMP_W = 64;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 16;

    localparam logic [2:0] OP_REGISTER   = 3'd0;
    localparam logic [2:0] OP_UNREGISTER = 3'd1;
    localparam logic [2:0] OP_SET_ID     = 3'd2;
    localparam logic [2:0] OP_SET_PANEL  = 3'd3;
    localparam logic [2:0] OP_SET_ELIG   = 3'd4;

    typedef struct packed {
        logic               eligible;
        logic               panel;
        logic [ID_W-1:0]    key;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

endpackage

// File: rtl/core/priority_owner_election.sv
// Owner election over a slot table held in one synchronous memory.
//
//  channel | dir | signals                      | beat contents
//  s       | in  | i_s_tvalid o_s_tready i_s_tdata | one table operation
//  m       | out | o_m_tvalid i_m_tready o_m_tdata | election result
//
// Each item passes through accept, read-modify-write of the addressed slot, a
// scan of the slot memory at one entry per cycle, and the result load. The scan
// goes through the single read port of the slot memory.
// Reset clears the valid flags, stamp counter and owner; memory data needs none.
// A stalled result holds in the output register and the next item is taken
// once the result has been loaded there.
module priority_owner_election #(
    parameter int SLOTS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // operation[2:0], slot[6:3], instance_id[38:7], panel[39], eligible[40]
    input  logic [poe_pkg::IN_W-1:0] i_s_tdata,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // owner_found[0], owner_slot[4:1], previous_found[5], previous_slot[9:6],
    // owner_changed[10]
    output logic [poe_pkg::OUT_W-1:0] o_m_tdata
);
    import poe_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = ((SW > 4) ? SW : 4) + 1;

    t_state             r_state, n_state;
    t_entry             r_slot_mem [SLOTS];
    t_entry             r_rd_data;
    logic [SW-1:0]      r_rd_idx;
    logic               r_rd_live;
    logic [SLOTS-1:0]   r_valid;
    logic [STAMP_W-1:0] r_stamp_cnt;

    logic [2:0]         r_op;
    logic [SW-1:0]      r_slot;
    logic               r_in_range;
    logic [ID_W-1:0]    r_id;
    logic               r_pn;
    logic               r_el;

    logic [SW:0]        r_scan;
    logic               r_best_found;
    logic [SW-1:0]      r_best_idx;
    logic               r_best_panel;
    logic [ID_W-1:0]    r_best_key;
    logic [STAMP_W-1:0] r_best_stamp;

    logic               r_owner_present;
    logic [SW-1:0]      r_owner_idx;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    logic               in_accept;
    logic [CW-1:0]      in_slot_ext;
    logic               in_range;
    logic [SW-1:0]      in_slot;
    logic [SW-1:0]      rd_addr;
    logic               scan_issue;
    logic               we;
    t_entry             wr_data;
    logic               cand_ok;
    logic               cand_beats;
    logic               out_free;
    logic               fin_load;
    logic [SW-1:0]      new_idx;
    logic               changed;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign in_slot_ext = CW'(i_s_tdata[6:3]);
    assign in_range    = in_slot_ext < CW'(SLOTS);
    assign in_slot     = in_range ? SW'(in_slot_ext) : '0;
    assign scan_issue  = (r_state == S_SCAN) && (r_scan < (SW + 1)'(SLOTS));

    always_comb begin
        unique case (r_state)
            S_SCAN:  rd_addr = scan_issue ? r_scan[SW-1:0] : '0;
            default: rd_addr = in_slot;
        endcase
    end

    always_comb begin
        we      = 1'b0;
        wr_data = r_rd_data;
        if (r_state == S_MOD && r_in_range) begin
            unique case (r_op)
                OP_REGISTER: begin
                    we      = 1'b1;
                    wr_data = '{eligible: r_el, panel: r_pn, key: r_id - ID_W'(1),
                                stamp: r_stamp_cnt + STAMP_W'(1)};
                end
                OP_SET_ID: begin
                    we          = r_valid[r_slot];
                    wr_data.key = r_id - ID_W'(1);
                end
                OP_SET_PANEL: begin
                    we            = r_valid[r_slot];
                    wr_data.panel = r_pn;
                end
                OP_SET_ELIG: begin
                    we               = r_valid[r_slot];
                    wr_data.eligible = r_el;
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_slot_mem[r_slot] <= wr_data;
        end
        r_rd_data <= r_slot_mem[rd_addr];
        r_rd_idx  <= rd_addr;
    end

    assign cand_ok = r_rd_live && r_valid[r_rd_idx] && r_rd_data.eligible;

    always_comb begin
        if (!r_best_found) begin
            cand_beats = 1'b1;
        end else if (r_rd_data.panel != r_best_panel) begin
            cand_beats = r_rd_data.panel;
        end else if (r_rd_data.key != r_best_key) begin
            cand_beats = r_rd_data.key < r_best_key;
        end else begin
            cand_beats = r_rd_data.stamp < r_best_stamp;
        end
    end

    assign out_free = !r_out_valid || i_m_tready;
    assign fin_load = (r_state == S_FIN) && out_free;
    assign new_idx  = r_best_found ? r_best_idx : '0;
    assign changed  = (r_best_found != r_owner_present) ||
                      (r_best_found && (r_best_idx != r_owner_idx));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_accept) begin
                n_state = S_MOD;
            end
            S_MOD: begin
                n_state = S_SCAN;
            end
            S_SCAN: if (r_scan == (SW + 1)'(SLOTS)) begin
                n_state = S_FIN;
            end
            S_FIN: if (out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_valid         <= '0;
            r_stamp_cnt     <= '0;
            r_rd_live       <= 1'b0;
            r_scan          <= '0;
            r_best_found    <= 1'b0;
            r_owner_present <= 1'b0;
            r_owner_idx     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_live <= scan_issue;
            if (in_accept) begin
                r_op       <= i_s_tdata[2:0];
                r_slot     <= in_slot;
                r_in_range <= in_range;
                r_id       <= i_s_tdata[38:7];
                r_pn       <= i_s_tdata[39];
                r_el       <= i_s_tdata[40];
            end
            if (r_state == S_MOD) begin
                r_scan       <= '0;
                r_best_found <= 1'b0;
                if (r_in_range && r_op == OP_REGISTER) begin
                    r_stamp_cnt     <= r_stamp_cnt + STAMP_W'(1);
                    r_valid[r_slot] <= 1'b1;
                end else if (r_in_range && r_op == OP_UNREGISTER) begin
                    r_valid[r_slot] <= 1'b0;
                end
            end
            if (r_state == S_SCAN) begin
                r_scan <= r_scan + (SW + 1)'(1);
                if (cand_ok && cand_beats) begin
                    r_best_found <= 1'b1;
                    r_best_idx   <= r_rd_idx;
                    r_best_panel <= r_rd_data.panel;
                    r_best_key   <= r_rd_data.key;
                    r_best_stamp <= r_rd_data.stamp;
                end
            end
            if (fin_load) begin
                r_out_valid     <= 1'b1;
                r_out_data      <= {5'b0, changed, 4'(r_owner_idx), r_owner_present,
                                    4'(new_idx), r_best_found};
                r_owner_present <= r_best_found;
                r_owner_idx     <= new_idx;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`include "priority_owner_election_assert.svh"

    `POE_ASSERT_NEXT(a_accept_to_mod, i_clk, i_rst_n, in_accept, r_state == S_MOD, "accepted beat did not start the slot update")
    `POE_ASSERT_NEXT(a_fin_loads_out, i_clk, i_rst_n, fin_load, o_m_tvalid && r_state == S_IDLE, "result beat not presented after the scan")
    `POE_ASSERT_NOW(a_owner_is_valid, i_clk, i_rst_n, r_state == S_IDLE && r_owner_present, r_valid[r_owner_idx], "elected owner slot is not registered")
    `POE_ASSERT_NOW(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, r_scan <= (SW + 1)'(SLOTS), "scan counter ran past the table")

endmodule

// File: sim/tb_priority_owner_election.sv
// Self-checking testbench for the priority owner election block.
`timescale 1ns / 100ps

module tb_priority_owner_election;
    import poe_pkg::*;

    localparam int SLOTS       = 16;
    localparam int ITEM_CYCLES = SLOTS + 4;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 240;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD7 = 3'd7;
    localparam logic [2:0] OP_RSVD6 = 3'd6;

    typedef struct packed {
        logic       changed;
        logic [3:0] prev_slot;
        logic       prev_found;
        logic [3:0] owner_slot;
        logic       owner_found;
    } t_election;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  slot;
        logic [31:0] id;
        logic        panel;
        logic        elig;
        logic        typed;
        t_election   want;
    } t_stim_row;

    localparam t_election NO_OWNER    = '0;
    localparam t_election FIRST_OWNER = '{changed: 1'b1, prev_slot: 4'd0, prev_found: 1'b0,
                                          owner_slot: 4'd15, owner_found: 1'b1};
    localparam t_election KEPT_OWNER  = '{changed: 1'b0, prev_slot: 4'd15, prev_found: 1'b1,
                                          owner_slot: 4'd15, owner_found: 1'b1};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    // operation[2:0], slot[6:3], instance_id[38:7], panel[39], eligible[40]
    logic [IN_W-1:0]      i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    // owner_found[0], owner_slot[4:1], previous_found[5], previous_slot[9:6],
    // owner_changed[10]
    logic [OUT_W-1:0]     o_m_tdata;

    bit        tbl_valid [SLOTS];
    bit        tbl_elig  [SLOTS];
    bit        tbl_panel [SLOTS];
    bit [31:0] tbl_id    [SLOTS];
    bit [63:0] tbl_stamp [SLOTS];
    bit [63:0] stamp_ctr;
    bit        owner_on;
    bit [3:0]  owner_at;

    t_election pending_elections [$];
    int        error_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_req;
    int        cycle_count;

    t_stim_row directed_rows [24] = '{
        '{OP_RSVD5,      4'd0,  32'd0,        1'b0, 1'b0, 1'b1, NO_OWNER},
        '{OP_SET_ID,     4'd3,  32'h12345678, 1'b0, 1'b0, 1'b1, NO_OWNER},
        '{OP_UNREGISTER, 4'd15, 32'd0,        1'b0, 1'b0, 1'b1, NO_OWNER},
        '{OP_REGISTER,   4'd15, 32'hFFFFFFFF, 1'b0, 1'b1, 1'b1, FIRST_OWNER},
        '{OP_REGISTER,   4'd0,  32'd0,        1'b0, 1'b1, 1'b1, KEPT_OWNER},
        '{OP_REGISTER,   4'd7,  32'd1,        1'b0, 1'b0, 1'b0, NO_OWNER},
        '{OP_SET_ELIG,   4'd7,  32'd0,        1'b0, 1'b1, 1'b0, NO_OWNER},
        '{OP_SET_PANEL,  4'd0,  32'd0,        1'b1, 1'b0, 1'b0, NO_OWNER},
        '{OP_SET_ID,     4'd0,  32'd5,        1'b0, 1'b0, 1'b0, NO_OWNER},
        '{OP_SET_PANEL,  4'd0,  32'd0,        1'b0, 1'b0, 1'b0, NO_OWNER},
        '{OP_REGISTER,   4'd9,  32'd1,        1'b0, 1'b1, 1'b0, NO_OWNER},
        '{OP_REGISTER,   4'd7,  32'd1,        1'b0, 1'b1, 1'b0, NO_OWNER},
        '{OP_UNREGISTER, 4'd9,  32'd0,        1'b0, 1'b0, 1'b0, NO_OWNER},
        '{OP_RSVD6,      4'd2,  32'd0,        1'b0, 1'b0, 1'b0, NO_OWNER},
        '{OP_RSVD7,      4'd15, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b0, NO_OWNER},
        '{OP_SET_ELIG,   4'd7,  32'd0,        1'b0, 1'b0, 1'b0, NO_OWNER},
        '{OP_REGISTER,   4'd4,  32'd0,        1'b1, 1'b1, 1'b0, NO_OWNER},
        '{OP_REGISTER,   4'd5,  32'd0,        1'b1, 1'b1, 1'b0, NO_OWNER},
        '{OP_SET_ID,     4'd5,  32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, NO_OWNER},
        '{OP_UNREGISTER, 4'd5,  32'd0,        1'b0, 1'b0, 1'b0, NO_OWNER},
        '{OP_UNREGISTER, 4'd4,  32'd0,        1'b0, 1'b0, 1'b0, NO_OWNER},
        '{OP_UNREGISTER, 4'd0,  32'd0,        1'b0, 1'b0, 1'b0, NO_OWNER},
        '{OP_UNREGISTER, 4'd15, 32'd0,        1'b0, 1'b0, 1'b0, NO_OWNER},
        '{OP_UNREGISTER, 4'd7,  32'd0,        1'b0, 1'b0, 1'b1, NO_OWNER}
    };

    priority_owner_election #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Instance id zero ranks below every nonzero id.
    function automatic bit outranks(int a, int b);
        logic [32:0] key_a;
        logic [32:0] key_b;
        if (tbl_panel[a] != tbl_panel[b]) begin
            return tbl_panel[a];
        end
        key_a = {tbl_id[a] == 32'd0, tbl_id[a]};
        key_b = {tbl_id[b] == 32'd0, tbl_id[b]};
        if (key_a != key_b) begin
            return key_a < key_b;
        end
        return tbl_stamp[a] < tbl_stamp[b];
    endfunction

    function automatic t_election elect_after(logic [2:0] op, logic [3:0] slot,
                                              logic [31:0] id, logic pn, logic el);
        t_election r;
        bit        found;
        int        best;
        found = 1'b0;
        best  = 0;
        case (op)
            OP_REGISTER: begin
                stamp_ctr++;
                tbl_valid[slot] = 1'b1;
                tbl_id[slot]    = id;
                tbl_panel[slot] = pn;
                tbl_elig[slot]  = el;
                tbl_stamp[slot] = stamp_ctr;
            end
            OP_UNREGISTER: begin
                tbl_valid[slot] = 1'b0;
                tbl_id[slot]    = '0;
                tbl_panel[slot] = 1'b0;
                tbl_elig[slot]  = 1'b0;
                tbl_stamp[slot] = '0;
            end
            OP_SET_ID: begin
                if (tbl_valid[slot]) tbl_id[slot] = id;
            end
            OP_SET_PANEL: begin
                if (tbl_valid[slot]) tbl_panel[slot] = pn;
            end
            OP_SET_ELIG: begin
                if (tbl_valid[slot]) tbl_elig[slot] = el;
            end
            default: ;
        endcase
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && tbl_elig[i] && (!found || outranks(i, best))) begin
                best  = i;
                found = 1'b1;
            end
        end
        r.prev_found  = owner_on;
        r.prev_slot   = owner_at;
        r.owner_found = found;
        r.owner_slot  = found ? best[3:0] : 4'd0;
        r.changed     = (found != owner_on) || (found && r.owner_slot != owner_at);
        owner_on      = found;
        owner_at      = r.owner_slot;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic offer_beat(logic [2:0] op, logic [3:0] slot, logic [31:0] id,
                              logic pn, logic el);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            gap = $urandom_range(1, 24);
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  = {{(IN_W - 41){1'b0}}, el, pn, id, slot, op};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_and_predict(logic [2:0] op, logic [3:0] slot, logic [31:0] id,
                                    logic pn, logic el, logic typed, t_election want);
        t_election r;
        offer_beat(op, slot, id, pn, el);
        r = elect_after(op, slot, id, pn, el);
        pending_elections.push_back(typed ? want : r);
    endtask

    // Mostly operations on live slots, with some noise on empty slots and spare codes.
    task automatic random_beat(output bit counted);
        int          pick;
        int          live [$];
        logic [2:0]  op;
        logic [3:0]  slot;
        logic [31:0] id;
        logic        pn;
        logic        el;
        pick = $urandom_range(99);
        if (pick < 30)      op = OP_REGISTER;
        else if (pick < 45) op = OP_UNREGISTER;
        else if (pick < 60) op = OP_SET_ID;
        else if (pick < 72) op = OP_SET_PANEL;
        else if (pick < 87) op = OP_SET_ELIG;
        else if (pick < 93) op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        else                op = 3'($urandom_range(OP_RSVD7));
        foreach (tbl_valid[i]) begin
            if (tbl_valid[i]) live.push_back(i);
        end
        if (op != OP_REGISTER && live.size() > 0 && pick < 93 && $urandom_range(9) < 8) begin
            slot = 4'(live[$urandom_range(live.size() - 1)]);
        end else begin
            slot = 4'($urandom_range(SLOTS - 1));
        end
        pick = $urandom_range(99);
        if (pick < 25)      id = 32'd0;
        else if (pick < 35) id = 32'hFFFFFFFF;
        else if (pick < 75) id = $urandom_range(1, 4);
        else                id = $urandom;
        pn = 1'($urandom_range(1));
        el = $urandom_range(99) < 70;
        counted = (op == OP_REGISTER) || (op <= OP_SET_ELIG && tbl_valid[slot]);
        send_and_predict(op, slot, id, pn, el, 1'b0, NO_OWNER);
    endtask

    initial begin
        int hold_left;
        bit hold_done;
        hold_left  = 0;
        hold_done  = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else begin
                i_m_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_election got;
        t_election want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[10:0];
            if (pending_elections.size() == 0) begin
                report_mismatch("result with no item pending", 32'(o_m_tdata), 32'd0);
            end else begin
                want = pending_elections.pop_front();
                if (got.owner_found !== want.owner_found)
                    report_mismatch("owner_found", 32'(got.owner_found),
                                    32'(want.owner_found));
                if (got.owner_slot !== want.owner_slot)
                    report_mismatch("owner_slot", 32'(got.owner_slot),
                                    32'(want.owner_slot));
                if (got.prev_found !== want.prev_found)
                    report_mismatch("previous_found", 32'(got.prev_found),
                                    32'(want.prev_found));
                if (got.prev_slot !== want.prev_slot)
                    report_mismatch("previous_slot", 32'(got.prev_slot),
                                    32'(want.prev_slot));
                if (got.changed !== want.changed)
                    report_mismatch("owner_changed", 32'(got.changed),
                                    32'(want.changed));
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int counted_items;
        bit counted;
        error_count   = 0;
        send_idle_pct = 20;
        recv_idle_pct = 83;
        hold_req      = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_rst_n       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k]) begin
            send_and_predict(directed_rows[k].op, directed_rows[k].slot, directed_rows[k].id,
                             directed_rows[k].panel, directed_rows[k].elig,
                             directed_rows[k].typed, directed_rows[k].want);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 83;
                end
                1: begin
                    send_idle_pct = 83;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // The sink holds off while items keep coming, so the input backs up.
                    hold_req = 1'b1;
                end
            endcase
            counted_items = 0;
            while (counted_items < PHASE_ITEMS) begin
                random_beat(counted);
                counted_items += counted;
            end
        end
        i_s_tvalid = 1'b0;

        while (pending_elections.size() != 0) @(posedge i_clk);
        repeat (2 * ITEM_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
